@@ hdl/ring_sector_point_test_macros.svh @@
// ----------------------------------------------------------------------------
// Ring sector point test assertion macros
// Shorthand for clocked implication checks with asynchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef RING_SECTOR_POINT_TEST_MACROS_SVH
`define RING_SECTOR_POINT_TEST_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RSP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/rsp_pkg.sv @@
// ----------------------------------------------------------------------------
// Ring sector point test package
// Shared constants, register indexes, control struct and the arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package rsp_pkg;

	localparam int COORD_BITS_DEF   = 24;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int ATAN_TABLE_LEN   = 24;

	// Angle accumulator width: quarter turn plus the whole table stays below 2^16.
	localparam int ZW      = 17;
	localparam int ANGLE_W = 16;
	localparam int PIXEL_W = 32;
	localparam int REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_CENTER_X     = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_CENTER_Y     = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_INNER_RADIUS = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_OUTER_RADIUS = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_ARC_BEGIN    = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_ARC_FINISH   = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_FILL_COLOR   = 3'd6;

	localparam int                        OUTER_RADIUS_RST = 65536;
	localparam logic signed [ANGLE_W-1:0] ARC_BEGIN_RST    = 16'sh8000;
	localparam logic signed [ANGLE_W-1:0] ARC_FINISH_RST   = 16'sh7FFF;
	localparam logic [PIXEL_W-1:0]        FILL_COLOR_RST   = 32'hFFFF_FFFF;

	localparam logic signed [ZW-1:0] ANGLE_MAX = 17'sd32767;
	localparam logic signed [ZW-1:0] ANGLE_MIN = -17'sd32768;
	localparam logic signed [ZW-1:0] QUARTER   = 17'sd16384;

	typedef struct packed {
		logic valid;
		logic zero;
	} rsp_ctl_t;

	// round(atan(2^-i) * 32768 / pi)
	function automatic logic signed [ZW-1:0] atan_unit(input int step);
		logic signed [ZW-1:0] r;
		unique case (step)
			0:       r = 17'sd8192;
			1:       r = 17'sd4836;
			2:       r = 17'sd2555;
			3:       r = 17'sd1297;
			4:       r = 17'sd651;
			5:       r = 17'sd326;
			6:       r = 17'sd163;
			7:       r = 17'sd81;
			8:       r = 17'sd41;
			9:       r = 17'sd20;
			10:      r = 17'sd10;
			11:      r = 17'sd5;
			12:      r = 17'sd3;
			13:      r = 17'sd1;
			14:      r = 17'sd1;
			default: r = 17'sd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

@@ hdl/rsp_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// Ring sector CORDIC cell
// One vectoring micro-rotation with a register on its outputs; carries the
// pixel and control flags along to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module rsp_cordic_cell
	import rsp_pkg::*;
#(
	parameter int XW     = 27,
	parameter int STEP   = 0,
	parameter int SIDE_W = 32
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    en,
	input  rsp_ctl_t               ctl_in,
	input  wire signed [XW-1:0]    x_in,
	input  wire signed [XW-1:0]    y_in,
	input  wire signed [ZW-1:0]    z_in,
	input  wire [SIDE_W-1:0]       side_in,
	output rsp_ctl_t               ctl_out,
	output logic signed [XW-1:0]   x_out,
	output logic signed [XW-1:0]   y_out,
	output logic signed [ZW-1:0]   z_out,
	output logic [SIDE_W-1:0]      side_out
);

	localparam logic signed [ZW-1:0] ATAN = atan_unit(STEP);

	logic signed [XW-1:0] xs;
	logic signed [XW-1:0] ys;
	logic signed [XW-1:0] x_nxt;
	logic signed [XW-1:0] y_nxt;
	logic signed [ZW-1:0] z_nxt;

	assign xs = x_in >>> STEP;
	assign ys = y_in >>> STEP;

	// Rotate toward the positive x axis; both updates use the old x and y.
	always_comb begin
		if (!y_in[XW-1]) begin
			x_nxt = x_in + ys;
			y_nxt = y_in - xs;
			z_nxt = z_in + ATAN;
		end else begin
			x_nxt = x_in - ys;
			y_nxt = y_in + xs;
			z_nxt = z_in - ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
		end else if (en) begin
			ctl_out <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_out    <= x_nxt;
			y_out    <= y_nxt;
			z_out    <= z_nxt;
			side_out <= side_in;
		end
	end

endmodule

`default_nettype wire

@@ hdl/ring_sector_point_test.sv @@
// ----------------------------------------------------------------------------
// Ring sector point test
// Decides per pixel whether a plane point lies in a ring sector around a
// configured center and paints it with the fill color when it does.
//
// The block takes one transfer per clock and returns one result transfer per
// input, in order: one stage forms the offset from the center, one squares
// it and folds the vector into the right half plane, a row of CORDIC_STEPS
// cells each performs one micro-rotation, and an output register applies the
// angle limits and picks the pixel. The whole pipe advances together and
// stalls only while a finished result waits in the output register with
// out_ready low, so with out_ready held high the sustained rate is one pixel
// per cycle. Radii are checked on squared values, both limits inclusive; the
// angle is a binary angle where 32768 means pi, with +pi reading as 32767,
// and must lie within arc_begin..arc_finish inclusive without wrapping.
// Configuration registers are to be written only while no transfer is in
// flight.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ring_sector_point_test_macros.svh"

module ring_sector_point_test
	import rsp_pkg::*;
#(
	parameter int COORD_BITS   = COORD_BITS_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	// Configuration write port
	input  wire                                   cfg_we,
	input  wire [REG_IDX_W-1:0]                   cfg_index,
	input  wire [((COORD_BITS > PIXEL_W) ? COORD_BITS : PIXEL_W)-1:0] cfg_data,
	// Pixel input channel
	input  wire                                   in_valid,
	output logic                                  in_ready,
	input  wire signed [COORD_BITS-1:0]           point_x,
	input  wire signed [COORD_BITS-1:0]           point_y,
	input  wire [PIXEL_W-1:0]                     pixel_in,
	// Result channel
	output logic                                  out_valid,
	input  wire                                   out_ready,
	output logic [PIXEL_W-1:0]                    pixel_out,
	output logic                                  inside_res
);

	localparam int CB    = COORD_BITS;
	localparam int N     = CORDIC_STEPS;
	localparam int DW    = CB + 1;        // offset from the center
	localparam int RAD_W = CB - 1;        // radius registers
	localparam int SQ_W  = 2 * CB;        // one squared offset
	localparam int R2_W  = 2 * RAD_W;     // one squared radius
	localparam int D2_W  = 2 * CB + 1;    // squared distance
	localparam int XW    = CB + 3;        // CORDIC datapath, covers the gain
	localparam int DLY_N = N - 2;         // radial flag delay behind the cells

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic signed [CB-1:0]      center_x_q;
	logic signed [CB-1:0]      center_y_q;
	logic [RAD_W-1:0]          inner_radius_q;
	logic [RAD_W-1:0]          outer_radius_q;
	logic signed [ANGLE_W-1:0] arc_begin_q;
	logic signed [ANGLE_W-1:0] arc_finish_q;
	logic [PIXEL_W-1:0]        fill_color_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q     <= '0;
			center_y_q     <= '0;
			inner_radius_q <= '0;
			outer_radius_q <= RAD_W'(OUTER_RADIUS_RST);
			arc_begin_q    <= ARC_BEGIN_RST;
			arc_finish_q   <= ARC_FINISH_RST;
			fill_color_q   <= FILL_COLOR_RST;
		end else if (cfg_we) begin
			// Indexes past the last register are ignored.
			unique case (cfg_index)
				REG_CENTER_X:     center_x_q     <= cfg_data[CB-1:0];
				REG_CENTER_Y:     center_y_q     <= cfg_data[CB-1:0];
				REG_INNER_RADIUS: inner_radius_q <= cfg_data[RAD_W-1:0];
				REG_OUTER_RADIUS: outer_radius_q <= cfg_data[RAD_W-1:0];
				REG_ARC_BEGIN:    arc_begin_q    <= cfg_data[ANGLE_W-1:0];
				REG_ARC_FINISH:   arc_finish_q   <= cfg_data[ANGLE_W-1:0];
				REG_FILL_COLOR:   fill_color_q   <= cfg_data[PIXEL_W-1:0];
				default: ;
			endcase
		end
	end

	// Squared radii follow the radius registers in the next cycle. The user is
	// to change the registers only while the pipe is empty; the block does not
	// enforce it. Kept so, these settle long before any item's radial compare.
	logic [R2_W-1:0] rin2_q;
	logic [R2_W-1:0] rout2_q;

	always_ff @(posedge clk) begin
		rin2_q  <= R2_W'(inner_radius_q) * R2_W'(inner_radius_q);
		rout2_q <= R2_W'(outer_radius_q) * R2_W'(outer_radius_q);
	end

	// ------------------------------------------------------------------
	// Pipeline control: every stage moves when the output register is free
	// or its result is being transferred out.
	// ------------------------------------------------------------------
	logic adv;

	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	// ------------------------------------------------------------------
	// Stage 1: offset from the center, at full precision.
	// ------------------------------------------------------------------
	logic                 v_s1;
	logic signed [DW-1:0] dx_s1;
	logic signed [DW-1:0] dy_s1;
	logic [PIXEL_W-1:0]   pix_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1  <= $signed({point_x[CB-1], point_x}) - $signed({center_x_q[CB-1], center_x_q});
			dy_s1  <= $signed({point_y[CB-1], point_y}) - $signed({center_y_q[CB-1], center_y_q});
			pix_s1 <= pixel_in;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: squares of the offset magnitudes, and the quarter turn that
	// brings a vector in the left half plane over to the right.
	// ------------------------------------------------------------------
	logic signed [DW-1:0] dx_neg;
	logic signed [DW-1:0] dy_neg;
	logic [CB-1:0]        ax;
	logic [CB-1:0]        ay;
	logic signed [XW-1:0] x0;
	logic signed [XW-1:0] y0;
	logic signed [ZW-1:0] z0;

	assign dx_neg = -dx_s1;
	assign dy_neg = -dy_s1;
	// The offset magnitude never exceeds 2^CB - 1, so CB bits hold it.
	assign ax = dx_s1[DW-1] ? dx_neg[CB-1:0] : dx_s1[CB-1:0];
	assign ay = dy_s1[DW-1] ? dy_neg[CB-1:0] : dy_s1[CB-1:0];

	always_comb begin
		if (dx_s1[DW-1]) begin
			if (!dy_s1[DW-1]) begin
				x0 = XW'(dy_s1);
				y0 = XW'(dx_neg);
				z0 = QUARTER;
			end else begin
				x0 = XW'(dy_neg);
				y0 = XW'(dx_s1);
				z0 = -QUARTER;
			end
		end else begin
			x0 = XW'(dx_s1);
			y0 = XW'(dy_s1);
			z0 = '0;
		end
	end

	rsp_ctl_t           ctl_s2;
	logic [SQ_W-1:0]    sx_s2;
	logic [SQ_W-1:0]    sy_s2;
	logic signed [XW-1:0] x_s2;
	logic signed [XW-1:0] y_s2;
	logic signed [ZW-1:0] z_s2;
	logic [PIXEL_W-1:0] pix_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (adv) begin
			ctl_s2.valid <= v_s1;
			ctl_s2.zero  <= (dx_s1 == '0) && (dy_s1 == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sx_s2  <= SQ_W'(ax) * SQ_W'(ax);
			sy_s2  <= SQ_W'(ay) * SQ_W'(ay);
			x_s2   <= x0;
			y_s2   <= y0;
			z_s2   <= z0;
			pix_s2 <= pix_s1;
		end
	end

	// ------------------------------------------------------------------
	// Radial side path, running beside the first two cells. The sum is kept
	// exact, so a squared distance beyond the squared radius width simply
	// compares above the outer radius, and reversed radii match no distance.
	// ------------------------------------------------------------------
	logic [D2_W-1:0] d2_s3;
	logic            rad_s4;
	logic            rad_dly_q [DLY_N];

	always_ff @(posedge clk) begin
		if (adv) begin
			d2_s3  <= D2_W'(sx_s2) + D2_W'(sy_s2);
			rad_s4 <= (d2_s3 >= D2_W'(rin2_q)) && (d2_s3 <= D2_W'(rout2_q));
			rad_dly_q[0] <= rad_s4;
			for (int k = 1; k < DLY_N; k++) begin
				rad_dly_q[k] <= rad_dly_q[k-1];
			end
		end
	end

	// ------------------------------------------------------------------
	// CORDIC cell row: cell i applies micro-rotation i.
	// ------------------------------------------------------------------
	rsp_ctl_t             ctl_c  [N+1];
	logic signed [XW-1:0] x_c    [N+1];
	logic signed [XW-1:0] y_c    [N+1];
	logic signed [ZW-1:0] z_c    [N+1];
	logic [PIXEL_W-1:0]   pix_c  [N+1];

	assign ctl_c[0] = ctl_s2;
	assign x_c[0]   = x_s2;
	assign y_c[0]   = y_s2;
	assign z_c[0]   = z_s2;
	assign pix_c[0] = pix_s2;

	for (genvar i = 0; i < N; i++) begin : g_cell
		rsp_cordic_cell #(
			.XW     (XW),
			.STEP   (i),
			.SIDE_W (PIXEL_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.ctl_in   (ctl_c[i]),
			.x_in     (x_c[i]),
			.y_in     (y_c[i]),
			.z_in     (z_c[i]),
			.side_in  (pix_c[i]),
			.ctl_out  (ctl_c[i+1]),
			.x_out    (x_c[i+1]),
			.y_out    (y_c[i+1]),
			.z_out    (z_c[i+1]),
			.side_out (pix_c[i+1])
		);
	end

	// ------------------------------------------------------------------
	// Output stage: saturate the angle, apply the arc limits and choose the
	// pixel. A vector of zero length has angle zero.
	// ------------------------------------------------------------------
	logic signed [ANGLE_W-1:0] ang;
	logic                      ang_ok;
	logic                      in_sector;
	logic                      last_valid;

	assign last_valid = ctl_c[N].valid;

	always_comb begin
		priority if (ctl_c[N].zero) begin
			ang = '0;
		end else if (z_c[N] > ANGLE_MAX) begin
			ang = ANGLE_MAX[ANGLE_W-1:0];
		end else if (z_c[N] < ANGLE_MIN) begin
			ang = ANGLE_MIN[ANGLE_W-1:0];
		end else begin
			ang = z_c[N][ANGLE_W-1:0];
		end
	end

	assign ang_ok    = (ang >= arc_begin_q) && (ang <= arc_finish_q);
	assign in_sector = rad_dly_q[DLY_N-1] && ang_ok;

	logic               out_valid_q;
	logic [PIXEL_W-1:0] pixel_out_q;
	logic               inside_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= last_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pixel_out_q <= in_sector ? fill_color_q : pix_c[N];
			inside_q    <= in_sector;
		end
	end

	assign out_valid  = out_valid_q;
	assign pixel_out  = pixel_out_q;
	assign inside_res = inside_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`RSP_ASSERT_NOW(a_fill_on_inside, clk, arst_n, out_valid && inside_res, pixel_out == fill_color_q, "inside result without fill color")
	`RSP_ASSERT_NOW(a_no_inside_rev_radii, clk, arst_n, out_valid && (inner_radius_q > outer_radius_q), !inside_res, "inside result with reversed radii")
	`RSP_ASSERT_NOW(a_no_inside_rev_arc, clk, arst_n, out_valid && (arc_begin_q > arc_finish_q), !inside_res, "inside result with reversed arc")
	`RSP_ASSERT_NEXT(a_out_from_row, clk, arst_n, adv && !last_valid, !out_valid, "result without an item leaving the cell row")

endmodule

`default_nettype wire
